>>> design/scup_pkg.sv
// ----------------------------------------------------------------------------
// Seven-bit character unpacker package
// Character widths, group sizes and the group hand-off type shared by the
// accumulator, the output buffer and the top level.
// ----------------------------------------------------------------------------
package scup_pkg;

   localparam int CHAR_W      = 7;
   localparam int BYTE_W      = 8;
   localparam int GROUP_BYTES = 7;
   localparam int GROUP_CHARS = 8;
   localparam int POS_W       = 3;   // holds the 1-based slot 1..7
   localparam int COUNT_W     = 4;   // holds a character count 0..8

   localparam logic [POS_W-1:0]   POS_FIRST = POS_W'(1);
   localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(GROUP_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(GROUP_CHARS);

   typedef logic [CHAR_W-1:0] char_type;

   // One finished group handed from the accumulator to the output buffer
   typedef struct packed {
      logic                              valid;
      char_type                          first;
      char_type [GROUP_BYTES-1:0]        chars;
      logic [COUNT_W-1:0]                count;
   } scup_load_type;

   // Output buffer status seen by the accumulator
   typedef struct packed {
      logic free;    // buffer can take a group at this edge
   } scup_buf_status_type;

endpackage

>>> design/seven_bit_char_unpacker.sv
// ----------------------------------------------------------------------------
// Seven-bit character unpacker
// Turns a stream of packed bytes into 7-bit characters, eight per group of
// seven bytes, with short tail groups at the end of the stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one packed byte per transfer; req_end_of_stream marks the
//   final byte of the stream. rsp_* carries one character per transfer;
//   rsp_last_of_run is high on the final character caused by a byte.
//   Bytes that do not close a group produce no characters and are taken
//   every cycle. A byte that closes a group (seventh byte, or a tail byte)
//   loads the whole group into the output buffer; the first character is
//   offered in the next cycle; the rest follow one per cycle unless stalled.
//   Output port sets throughput: one character per cycle unless stalled, so a
//   full group of 7 bytes gives 8 characters and a tail group of m bytes
//   gives m. A closing byte waits on req_ready only while the buffer still
//   holds characters of the previous group; it may enter at the edge where
//   that group's final character is transferred.
//   When the receiver stalls, the current character holds, and bytes keep
//   being collected until the next closing byte.
//   Reset (synchronous) empties the buffer and restarts the group at slot 1.
// ----------------------------------------------------------------------------
module seven_bit_char_unpacker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [scup_pkg::BYTE_W-1:0]         req_packed_byte,
   input  logic                                req_end_of_stream,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [scup_pkg::CHAR_W-1:0]         rsp_char_out,
   output logic                                rsp_last_of_run
);

   scup_pkg::scup_load_type          load;
   scup_pkg::scup_buf_status_type    buf_status;

   // Byte collection
   scup_group_acc u_group_acc (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_packed_byte   (req_packed_byte),
      .req_end_of_stream (req_end_of_stream),
      .buf_status        (buf_status),
      .load              (load)
   );

   // Character output
   scup_out_buf u_out_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .buf_status      (buf_status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // A group is only handed over when the buffer has room
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> buf_status.free)
      else $error("group loaded into a busy output buffer");

   // A loaded group carries between one and eight characters
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> (load.count != '0) && (load.count <= scup_pkg::COUNT_FULL))
      else $error("group character count out of range");

   // After the final character leaves with no new group, the output is empty
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run && !load.valid) |=> !rsp_valid)
      else $error("output still valid after final character");

   // A closing transfer makes characters available in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load.valid |=> rsp_valid)
      else $error("loaded group not presented");

endmodule

>>> design/scup_group_acc.sv
// ----------------------------------------------------------------------------
// Group accumulator
// Collects the bytes of one group: the top bits build character 1, the low
// seven bits are stored per slot. A full group or a tail byte closes the
// group and hands it to the output buffer in the same cycle.
// ----------------------------------------------------------------------------
module scup_group_acc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [scup_pkg::BYTE_W-1:0]         req_packed_byte,
   input  logic                                req_end_of_stream,
   input  scup_pkg::scup_buf_status_type       buf_status,
   output scup_pkg::scup_load_type             load
);

   logic [scup_pkg::POS_W-1:0]   pos_ff, pos_in;
   scup_pkg::char_type           acc_ff, acc_in;
   scup_pkg::char_type           store_ff [scup_pkg::GROUP_BYTES];

   logic [scup_pkg::POS_W-1:0]   slot_idx;
   scup_pkg::char_type           low_bits;
   scup_pkg::char_type           acc_new;
   logic                         closing;
   logic                         full_group;
   logic                         transfer;

   // Current slot and the merged character 1
   assign slot_idx   = pos_ff - scup_pkg::POS_FIRST;
   assign low_bits   = req_packed_byte[scup_pkg::CHAR_W-1:0];
   assign acc_new    = acc_ff | (scup_pkg::CHAR_W'(req_packed_byte[scup_pkg::BYTE_W-1])
                                 << slot_idx);
   assign full_group = (pos_ff == scup_pkg::POS_LAST);
   assign closing    = full_group | req_end_of_stream;

   // A byte that closes a group needs room in the output buffer
   assign req_ready = buf_status.free | ~closing;
   assign transfer  = req_valid & req_ready;

   // Group hand-off
   always_comb begin
      load.valid = transfer & closing;
      load.first = full_group ? acc_new : (acc_new | low_bits);
      for (int k = 0; k < scup_pkg::GROUP_BYTES; k++) begin
         load.chars[k] = (slot_idx == scup_pkg::POS_W'(k)) ? low_bits : store_ff[k];
      end
      load.count = full_group ? scup_pkg::COUNT_FULL : scup_pkg::COUNT_W'(pos_ff);
   end

   // Next group state
   always_comb begin
      pos_in = pos_ff;
      acc_in = acc_ff;
      if (transfer) begin
         if (closing) begin
            pos_in = scup_pkg::POS_FIRST;
            acc_in = '0;
         end else begin
            pos_in = pos_ff + scup_pkg::POS_W'(1);
            acc_in = acc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= scup_pkg::POS_FIRST;
         acc_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         acc_ff <= acc_in;
      end
   end

   // Character store, written at the current slot
   always_ff @(posedge clock) begin
      if (transfer) begin
         store_ff[slot_idx] <= low_bits;
      end
   end

endmodule

>>> design/scup_out_buf.sv
// ----------------------------------------------------------------------------
// Output buffer
// Holds one finished group as a shift line of characters and sends them one
// per transfer, flagging the final character of the group.
// ----------------------------------------------------------------------------
module scup_out_buf (
   input  logic                                clock,
   input  logic                                reset,
   input  scup_pkg::scup_load_type             load,
   output scup_pkg::scup_buf_status_type       buf_status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [scup_pkg::CHAR_W-1:0]         rsp_char_out,
   output logic                                rsp_last_of_run
);

   scup_pkg::char_type [scup_pkg::GROUP_CHARS-1:0] slot_ff, slot_in;
   logic [scup_pkg::COUNT_W-1:0]                   count_ff, count_in;
   logic                                           transfer;

   assign rsp_valid       = (count_ff != '0);
   assign rsp_char_out    = slot_ff[0];
   assign rsp_last_of_run = (count_ff == scup_pkg::COUNT_W'(1));
   assign transfer        = rsp_valid & rsp_ready;

   // Free when empty, or when the final character leaves at this edge
   assign buf_status.free = ~rsp_valid | (rsp_last_of_run & rsp_ready);

   // Load a new group or shift toward the output
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (load.valid) begin
         slot_in[0] = load.first;
         for (int k = 0; k < scup_pkg::GROUP_BYTES; k++) begin
            slot_in[k+1] = load.chars[k];
         end
         count_in = load.count;
      end else if (transfer) begin
         for (int k = 0; k < scup_pkg::GROUP_CHARS - 1; k++) begin
            slot_in[k] = slot_ff[k+1];
         end
         count_in = count_ff - scup_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
